@@ rtl/ucw_pkg.sv @@
// Package with the shared types, constants and the combining-range table of the width classifier.
package ucw_pkg;

  localparam int CP_W    = 21;
  localparam int WIDTH_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ROM_SIZE  = 142;
  localparam int ROM_LEN_W = 8;
  localparam int ROM_ENTRY_W = CP_W + ROM_LEN_W;

  typedef logic [CP_W-1:0]        cp_t;
  typedef logic [WIDTH_W-1:0]     width_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [ROM_ENTRY_W-1:0] rom_entry_t;

  // Display widths.
  localparam width_t WIDTH_ZERO   = 2'd0;
  localparam width_t WIDTH_SINGLE = 2'd1;
  localparam width_t WIDTH_DOUBLE = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_WIDE_ENABLE    = 2'd0;
  localparam cfg_idx_t CFG_EMOJI_WIDE     = 2'd1;
  localparam cfg_idx_t CFG_CJK_PLANE_WIDE = 2'd2;

  // Mode flags handed from the register block to the classifier.
  typedef struct packed {
    logic wide_enable;
    logic emoji_wide;
    logic cjk_plane_wide;
  } mode_t;

  // Combining ranges, each entry packed as first code point << 8 | (last - first).
  localparam rom_entry_t NONSPACING_ROM [ROM_SIZE] = '{
    29'h3006f, 29'h48303, 29'h48801, 29'h5912c, 29'h5bf00, 29'h5c101, 29'h5c401, 29'h5c700,
    29'h60003, 29'h61005, 29'h64b13, 29'h67000, 29'h6d60e, 29'h6e701, 29'h6ea03, 29'h70f00,
    29'h71100, 29'h7301a, 29'h7a60a, 29'h7eb08, 29'h90101, 29'h93c00, 29'h94107, 29'h94d00,
    29'h95103, 29'h96201, 29'h98100, 29'h9bc00, 29'h9c103, 29'h9cd00, 29'h9e201, 29'ha0101,
    29'ha3c00, 29'ha4101, 29'ha4701, 29'ha4b02, 29'ha7001, 29'ha8101, 29'habc00, 29'hac104,
    29'hac701, 29'hacd00, 29'hae201, 29'hb0100, 29'hb3c00, 29'hb3f00, 29'hb4102, 29'hb4d00,
    29'hb5600, 29'hb8200, 29'hbc000, 29'hbcd00, 29'hc3e02, 29'hc4602, 29'hc4a03, 29'hc5501,
    29'hcbc00, 29'hcbf00, 29'hcc600, 29'hccc01, 29'hce201, 29'hd4102, 29'hd4d00, 29'hdca00,
    29'hdd202, 29'hdd600, 29'he3100, 29'he3406, 29'he4707, 29'heb100, 29'heb405, 29'hebb01,
    29'hec805, 29'hf1801, 29'hf3500, 29'hf3700, 29'hf3900, 29'hf710d, 29'hf8004, 29'hf8601,
    29'hf9007, 29'hf9923, 29'hfc600,
    29'h102d03, 29'h103200, 29'h103601, 29'h103900, 29'h105801, 29'h11609f, 29'h135f00,
    29'h171202, 29'h173202, 29'h175201, 29'h177201, 29'h17b401, 29'h17b706, 29'h17c600,
    29'h17c90a, 29'h17dd00, 29'h180b02, 29'h18a900, 29'h192002, 29'h192701, 29'h193200,
    29'h193902, 29'h1a1701, 29'h1b0003, 29'h1b3400, 29'h1b3604, 29'h1b3c00, 29'h1b4200,
    29'h1b6b08, 29'h1dc00a, 29'h1dfe01, 29'h200b04, 29'h202a04, 29'h206003, 29'h206a05,
    29'h20d01f, 29'h302a05, 29'h309901, 29'ha80600, 29'ha80b00, 29'ha82501, 29'hfb1e00,
    29'hfe000f, 29'hfe2003, 29'hfeff00, 29'hfff902,
    29'h10a0102, 29'h10a0501, 29'h10a0c03, 29'h10a3802, 29'h10a3f00, 29'h1d16702,
    29'h1d1730f, 29'h1d18506, 29'h1d1aa03, 29'h1d24202, 29'he000100, 29'he00205f,
    29'he0100ef
  };

endpackage

@@ rtl/ucw_if.sv @@
// Interfaces for the code point, width and configuration channels.
interface ucw_cp_if;
  logic            valid;
  logic            ready;
  ucw_pkg::cp_t    code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
  modport mon    (input valid, input code_point, input ready);
endinterface

interface ucw_width_if;
  logic            valid;
  logic            ready;
  ucw_pkg::width_t width;

  modport source (output valid, output width, input ready);
  modport sink   (input valid, input width, output ready);
  modport mon    (input valid, input width, input ready);
endinterface

interface ucw_cfg_if;
  logic              valid;
  logic              ready;
  ucw_pkg::cfg_idx_t index;
  logic              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

@@ rtl/ucw_classify.sv @@
// Combinational display-width classifier for one code point.
module ucw_classify (
  input  ucw_pkg::cp_t    code_point,
  input  ucw_pkg::mode_t  mode,
  output ucw_pkg::width_t width
);

  logic [ucw_pkg::ROM_SIZE-1:0] hit;
  logic                         nonspacing;
  logic                         wide;
  logic                         is_control;

  // Every range is compared in parallel; the table is constant so the bounds fold away.
  always_comb begin
    for (int i = 0; i < ucw_pkg::ROM_SIZE; i++) begin
      logic [ucw_pkg::CP_W:0] first;
      logic [ucw_pkg::CP_W:0] last;
      first = {1'b0, ucw_pkg::NONSPACING_ROM[i][ucw_pkg::ROM_ENTRY_W-1:ucw_pkg::ROM_LEN_W]};
      last  = first + {{(ucw_pkg::CP_W + 1 - ucw_pkg::ROM_LEN_W){1'b0}},
                       ucw_pkg::NONSPACING_ROM[i][ucw_pkg::ROM_LEN_W-1:0]};
      hit[i] = ({1'b0, code_point} >= first) && ({1'b0, code_point} <= last);
    end
  end

  assign nonspacing = |hit;

  assign is_control = (code_point < 21'h20) || (code_point == 21'h7f);

  assign wide =
      (code_point >= 21'h1100 && code_point <= 21'h115f) ||
      (code_point == 21'h2329 || code_point == 21'h232a) ||
      (code_point >= 21'h2e80 && code_point <= 21'ha4cf && code_point != 21'h303f) ||
      (code_point >= 21'hac00 && code_point <= 21'hd7a3) ||
      (code_point >= 21'hf900 && code_point <= 21'hfaff) ||
      (code_point >= 21'hfe10 && code_point <= 21'hfe19) ||
      (code_point >= 21'hfe30 && code_point <= 21'hfe6f) ||
      (code_point >= 21'hff00 && code_point <= 21'hff60) ||
      (code_point >= 21'hffe0 && code_point <= 21'hffe6) ||
      (mode.emoji_wide && code_point >= 21'h1f18e && code_point <= 21'h1f9ff) ||
      (mode.cjk_plane_wide &&
       ((code_point >= 21'h20000 && code_point <= 21'h2fffd) ||
        (code_point >= 21'h30000 && code_point <= 21'h3fffd)));

  always_comb begin
    if (code_point == '0) begin
      width = ucw_pkg::WIDTH_ZERO;
    end else if (is_control) begin
      width = ucw_pkg::WIDTH_DOUBLE;
    end else if (nonspacing) begin
      width = ucw_pkg::WIDTH_ZERO;
    end else if (!mode.wide_enable) begin
      width = ucw_pkg::WIDTH_SINGLE;
    end else if (wide) begin
      width = ucw_pkg::WIDTH_DOUBLE;
    end else begin
      width = ucw_pkg::WIDTH_SINGLE;
    end
  end

endmodule

@@ rtl/unicode_char_width.sv @@
// Top level of the Unicode display-width classifier.
//
// Each code_point transaction on in_chan yields exactly one width transaction
// on out_chan, in order: 0 for code point zero and for combining or format
// characters, 2 for C0 controls and DEL (shown as caret pairs), otherwise 1,
// or 2 for East Asian wide characters when wide_enable is set, with the emoji
// block and the supplementary CJK planes widened only under their own flags.
// The block has two register stages: a code point is captured in the input
// stage, classified by one pass of combinational range compares, and the
// width lands in the output register, which drives out_chan.valid. A new
// transaction is accepted every cycle as long as the output side keeps
// taking results; a waiting result in the output register does not stop
// the input stage from holding one more item.
// Configuration writes on cfg_chan are always accepted and must only be
// issued while no transaction is in flight.
module unicode_char_width (
  input  logic       clk,
  input  logic       rst_n,
  ucw_cp_if.sink     in_chan,
  ucw_width_if.source out_chan,
  ucw_cfg_if.sink    cfg_chan
);

  // Mode registers, written through the configuration channel.
  ucw_pkg::mode_t mode_r;
  ucw_pkg::mode_t mode_nxt;

  // Input stage holds one accepted code point.
  logic           s1_valid_r;
  logic           s1_valid_nxt;
  ucw_pkg::cp_t   s1_cp_r;
  ucw_pkg::cp_t   s1_cp_nxt;

  // Output register holds one finished width.
  logic            out_valid_r;
  logic            out_valid_nxt;
  ucw_pkg::width_t out_width_r;
  ucw_pkg::width_t out_width_nxt;

  ucw_pkg::width_t class_width;
  logic            s1_move;
  logic            in_accept;

  // The input stage may advance whenever the output register is empty or is
  // being emptied in this cycle.
  assign s1_move   = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign in_accept = in_chan.valid && in_chan.ready;

  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid = out_valid_r;
  assign out_chan.width = out_width_r;

  ucw_classify u_classify (
    .code_point (s1_cp_r),
    .mode       (mode_r),
    .width      (class_width)
  );

  // Only bit 0 of a write is kept; an index past the last register is dropped.
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        ucw_pkg::CFG_WIDE_ENABLE:    mode_nxt.wide_enable    = cfg_chan.data;
        ucw_pkg::CFG_EMOJI_WIDE:     mode_nxt.emoji_wide     = cfg_chan.data;
        ucw_pkg::CFG_CJK_PLANE_WIDE: mode_nxt.cjk_plane_wide = cfg_chan.data;
        default:                     mode_nxt = mode_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_cp_nxt    = s1_cp_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      s1_cp_nxt    = in_chan.code_point;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_width_nxt = out_width_r;
    if (s1_move) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_width_nxt = class_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_cp_r     <= s1_cp_nxt;
    out_width_r <= out_width_nxt;
  end

endmodule

@@ rtl/ucw_checker.sv @@
// Port-level assertions for the width classifier, bound to the top level.
module ucw_checker (
  input logic         clk,
  input logic         rst_n,
  ucw_cp_if.sink      in_chan,
  ucw_width_if.source out_chan
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  // The width code three is never produced.
  a_width_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.width != 2'd3)
    else $error("illegal width code");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(out_chan.width)))
    else $error("stalled result changed");

  // Input back-pressure only ever comes from a full, stalled output side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without output back-pressure");

endmodule

bind unicode_char_width ucw_checker u_ucw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
